FILE: src/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // Default geometry
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STEP_DEF = 8;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int CELL_IDX_W = 11;
    localparam int CELL_W     = 16;
    localparam int CURSOR_W   = 11;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int COLOR_W    = 4;
    localparam int ATTR_W     = 2 * COLOR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR = 1'b1;
    localparam logic [COLOR_W-1:0]   BACK_RESET     = 4'd0;
    localparam logic [COLOR_W-1:0]   FORE_RESET     = 4'd7;

    // One finished result
    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [CURSOR_W-1:0]  cursor_location;
        logic [COL_OUT_W-1:0] column;
        logic [ROW_OUT_W-1:0] row;
    } t_result;

endpackage

`default_nettype wire

FILE: src/text_console_writer_top.sv
`default_nettype none

// Channel  Dir  Handshake                 Fields
// in       in   i_in_valid / o_in_stall   i_mode, i_char_code, i_cell_index
// out      out  o_out_valid / i_out_stall o_cell_value, o_cursor_location, o_column, o_row
// cfg      in   i_cfg_we                  i_cfg_index, i_cfg_data
//
// A put that does not scroll passes through the execute and result states to the
// output register; a read adds a read state for the registered buffer read.
// A line end on the bottom row scrolls, the single write port of the buffer RAM
// copying one cell per cycle; the bottom row is then cleared.
// A clear walks the whole buffer.
// After reset a clearing pass over the whole buffer runs before the first
// item transfer; configuration writes are taken during it.
// A result waiting on i_out_stall holds the sequencer; one item may be taken
// while a finished result waits in the output register.

module text_console_writer_top #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input items
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [tcw_pkg::MODE_W-1:0]        i_mode,
    input  wire [tcw_pkg::CHAR_W-1:0]        i_char_code,
    input  wire [tcw_pkg::CELL_IDX_W-1:0]    i_cell_index,
    // results
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [tcw_pkg::CELL_W-1:0]       o_cell_value,
    output logic [tcw_pkg::CURSOR_W-1:0]     o_cursor_location,
    output logic [tcw_pkg::COL_OUT_W-1:0]    o_column,
    output logic [tcw_pkg::ROW_OUT_W-1:0]    o_row,
    // configuration
    input  wire                              i_cfg_we,
    input  wire [tcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [tcw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int A_W   = $clog2(CELLS);

    logic [COLOR_W-1:0] r_back_color;
    logic [COLOR_W-1:0] r_fore_color;
    logic               r_out_valid;
    t_result            r_out;

    logic               in_ready;
    logic               res_valid;
    logic               res_take;
    t_result            res;
    logic               mem_we;
    logic [A_W-1:0]     mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [A_W-1:0]     mem_raddr;
    logic [CELL_W-1:0]  mem_rdata;

    assign o_in_stall = !in_ready;
    assign res_take   = !r_out_valid || !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_color <= BACK_RESET;
            r_fore_color <= FORE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BACK_COLOR: r_back_color <= i_cfg_data[COLOR_W-1:0];
                REG_FORE_COLOR: r_fore_color <= i_cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tcw_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (in_ready),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_attr       ({r_back_color, r_fore_color}),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    tcw_ram #(
        .DEPTH  (CELLS),
        .DATA_W (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: load on a free slot, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cell_value      = r_out.cell_value;
    assign o_cursor_location = r_out.cursor_location;
    assign o_column          = r_out.column;
    assign o_row             = r_out.row;

    // Checks
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item taken while the previous one is still in work");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_take) |=> (res_valid && $stable(res)))
        else $error("pending result lost while the output register was full");

    a_position_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((int'(o_column) < COLUMNS) && (int'(o_row) < ROWS)))
        else $error("write position outside the screen");

endmodule

`default_nettype wire

FILE: src/tcw_ram.sv
`default_nettype none

module tcw_ram #(
    parameter int DEPTH  = 2000,
    parameter int DATA_W = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [DATA_W-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // item transfer
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire [tcw_pkg::MODE_W-1:0]            i_mode,
    input  wire [tcw_pkg::CHAR_W-1:0]            i_char_code,
    input  wire [tcw_pkg::CELL_IDX_W-1:0]        i_cell_index,
    input  wire [tcw_pkg::ATTR_W-1:0]            i_attr,
    // result handoff
    output logic                                 o_res_valid,
    input  wire                                  i_res_take,
    output tcw_pkg::t_result                     o_res,
    // buffer memory port
    output logic                                 o_mem_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      o_mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]           o_mem_wdata,
    output logic                                 o_mem_re,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      o_mem_raddr,
    input  wire [tcw_pkg::CELL_W-1:0]            i_mem_rdata
);

    import tcw_pkg::*;

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int LAST_ROW = CELLS - COLUMNS;
    localparam int A_W      = $clog2(CELLS);
    localparam int C_W      = $clog2(COLUMNS);
    localparam int R_W      = $clog2(ROWS);
    localparam int CX_W     = $clog2(COLUMNS + TAB_STEP);
    localparam int IDX_CMP_W = (A_W + 1 > CELL_IDX_W) ? A_W + 1 : CELL_IDX_W + 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_CLEAR  = 6'b010000,
        ST_RESULT = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [A_W-1:0]      r_ptr, n_ptr;
    logic                r_cp_vld, n_cp_vld;
    logic [A_W-1:0]      r_cp_addr, n_cp_addr;
    logic                r_init, n_init;
    logic [C_W-1:0]      r_col, n_col;
    logic [R_W-1:0]      r_row, n_row;
    logic [CURSOR_W-1:0] r_cursor, n_cursor;
    logic [MODE_W-1:0]   r_mode;
    logic [CHAR_W-1:0]   r_char;
    logic [CELL_IDX_W-1:0] r_cell;
    logic [CELL_W-1:0]   r_value, n_value;
    logic                r_rd_ok, n_rd_ok;

    logic [CX_W-1:0]     col_ext;
    logic                newline;
    logic [R_W-1:0]      nl_row;
    logic                need_scroll;
    logic [A_W-1:0]      wr_addr;
    logic                cell_ok;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_RESULT);

    assign o_res.cell_value      = r_value;
    assign o_res.cursor_location = r_cursor;
    assign o_res.column          = COL_OUT_W'(r_col);
    assign o_res.row             = ROW_OUT_W'(r_row);

    // Write position of the current cell and range of a read
    assign wr_addr = A_W'(r_row) * A_W'(COLUMNS) + A_W'(r_col);
    assign cell_ok = IDX_CMP_W'(r_cell) < IDX_CMP_W'(CELLS);

    // Column advance for a put
    always_comb begin
        newline = 1'b0;
        col_ext = CX_W'(r_col);
        case (r_char)
            CH_NEWLINE: newline = 1'b1;
            CH_TAB:     col_ext = CX_W'(r_col) + CX_W'(TAB_STEP);
            default:    col_ext = CX_W'(r_col) + CX_W'(1);
        endcase
        if (col_ext >= CX_W'(COLUMNS)) begin
            newline = 1'b1;
        end
        need_scroll = (r_row == R_W'(ROWS - 1));
        nl_row      = need_scroll ? r_row : r_row + R_W'(1);
    end

    // Sequencer and memory port drive
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_cp_vld  = r_cp_vld;
        n_cp_addr = r_cp_addr;
        n_init    = r_init;
        n_col     = r_col;
        n_row     = r_row;
        n_cursor  = r_cursor;
        n_value   = r_value;
        n_rd_ok   = r_rd_ok;

        o_mem_we    = 1'b0;
        o_mem_waddr = r_ptr;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ptr + A_W'(COLUMNS);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_value = '0;
                n_state = ST_RESULT;
                case (r_mode)
                    MODE_PUT: begin
                        if (r_char != CH_NEWLINE && r_char != CH_TAB) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = wr_addr;
                            o_mem_wdata = {i_attr, r_char};
                        end
                        if (newline) begin
                            n_col    = '0;
                            n_row    = nl_row;
                            n_cursor = CURSOR_W'(A_W'(nl_row) * A_W'(COLUMNS));
                            if (need_scroll) begin
                                n_ptr    = '0;
                                n_cp_vld = 1'b0;
                                n_state  = ST_SCROLL;
                            end
                        end else begin
                            n_col = C_W'(col_ext);
                        end
                    end
                    MODE_CLEAR: begin
                        n_col    = '0;
                        n_row    = '0;
                        n_cursor = '0;
                        n_ptr    = '0;
                        n_state  = ST_CLEAR;
                    end
                    MODE_READ: begin
                        o_mem_re    = cell_ok;
                        o_mem_raddr = A_W'(r_cell);
                        n_rd_ok     = cell_ok;
                        n_state     = ST_READ;
                    end
                    default: begin
                    end
                endcase
            end
            ST_READ: begin
                n_value = r_rd_ok ? i_mem_rdata : '0;
                n_state = ST_RESULT;
            end
            ST_SCROLL: begin
                // retire the copy read last cycle, issue the next one
                if (r_cp_vld) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_cp_addr;
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_ptr < A_W'(LAST_ROW)) begin
                    o_mem_re  = 1'b1;
                    n_cp_vld  = 1'b1;
                    n_cp_addr = r_ptr;
                    n_ptr     = r_ptr + A_W'(1);
                end else begin
                    n_cp_vld = 1'b0;
                    n_state  = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr;
                if (r_ptr == A_W'(CELLS - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? ST_IDLE : ST_RESULT;
                end else begin
                    n_ptr = r_ptr + A_W'(1);
                end
            end
            ST_RESULT: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ptr    <= '0;
            r_cp_vld <= 1'b0;
            r_init   <= 1'b1;
            r_col    <= '0;
            r_row    <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_cp_vld <= n_cp_vld;
            r_init   <= n_init;
            r_col    <= n_col;
            r_row    <= n_row;
            r_cursor <= n_cursor;
        end
    end

    // Item and payload holding
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_mode <= i_mode;
            r_char <= i_char_code;
            r_cell <= i_cell_index;
        end
        r_cp_addr <= n_cp_addr;
        r_value   <= n_value;
        r_rd_ok   <= n_rd_ok;
    end

endmodule

`default_nettype wire
